// ===== rtl/cbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants for the cartridge bank mapper
// Result kinds, configuration register indexes and the decode word.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_ADDR_W = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int BANK_OFS_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROM_MASK       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_MASK       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_BANK_COUNT = 2'd2;

  localparam logic [DATA_W-1:0] OPEN_BUS_BYTE = 8'hFF;
  localparam logic [DATA_W-1:0] RAM_EN_KEY    = 8'h0A;

  typedef enum logic [1:0] {
    KIND_ROM   = 2'd0,
    KIND_RAM   = 2'd1,
    KIND_OPEN  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [ROM_ADDR_W-1:0]  rom_address;
    logic                   ram_en;
    logic                   ram_we;
  } dec_t;

endpackage
`default_nettype wire

// ===== rtl/cbm_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_in_if: bus access channel
// One word is one CPU bus access: mode, address and write data.
// ----------------------------------------------------------------------------
interface cbm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [cbm_pkg::ADDR_W-1:0]    bus_address;
  logic [cbm_pkg::DATA_W-1:0]    write_data;

  modport source(output valid, mode, bus_address, write_data, input ready);
  modport sink(input valid, mode, bus_address, write_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbm_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_out_if: result channel
// One word per access: kind, read byte and ROM address.
// ----------------------------------------------------------------------------
interface cbm_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      access_kind;
  logic [cbm_pkg::DATA_W-1:0]      read_data;
  logic [cbm_pkg::ROM_ADDR_W-1:0]  rom_address;

  modport source(output valid, access_kind, read_data, rom_address, input ready);
  modport sink(input valid, access_kind, read_data, rom_address, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbm_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_cfg_if: configuration write channel
// One word writes one configuration register.
// ----------------------------------------------------------------------------
interface cbm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cbm_pkg::CFG_IDX_W-1:0]     index;
  logic [cbm_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cartridge_bank_mapper_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_top: cartridge bank controller
// Pipeline: two register stages (s1, output), RAM read data registered in the
// RAM; an accepted bus word moves on from s1 when the output is free or taken.
// Throughput: one access per cycle unless the result channel stalls; the
// single cart RAM port is used at most once per access (read or write).
// Reset clears bank and config registers and the pipeline; cart RAM keeps
// its contents, no clearing pass.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_top #(
  parameter int RAM_BANK_NUM  = 4,
  parameter int ROM_SEL_BITS  = 5
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cbm_in_if.sink     bus,
  cbm_out_if.source  result,
  cbm_cfg_if.sink    cfg
);

  localparam int RAM_DEPTH = RAM_BANK_NUM * 8192;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  cbm_pkg::dec_t                        dec;
  logic [RAM_AW-1:0]                    ram_addr;
  logic [cbm_pkg::DATA_W-1:0]           ram_rdata;
  logic                                 acc;
  logic                                 adv;

  logic                                 s1_valid;
  cbm_pkg::kind_t                       s1_kind;
  logic [cbm_pkg::ROM_ADDR_W-1:0]       s1_rom_address;

  logic                                 out_valid;
  cbm_pkg::kind_t                       out_kind;
  logic [cbm_pkg::DATA_W-1:0]           out_read_data;
  logic [cbm_pkg::ROM_ADDR_W-1:0]       out_rom_address;
  logic [cbm_pkg::DATA_W-1:0]           read_data_next;

  assign cfg.ready = 1'b1;
  assign adv       = s1_valid && (!out_valid || result.ready);
  assign bus.ready = !s1_valid || adv;
  assign acc       = bus.valid && bus.ready;

  cbm_ctrl #(
    .RAM_BANK_NUM  (RAM_BANK_NUM),
    .ROM_SEL_BITS  (ROM_SEL_BITS),
    .RAM_AW        (RAM_AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .acc         (acc),
    .mode        (bus.mode),
    .bus_address (bus.bus_address),
    .write_data  (bus.write_data),
    .dec         (dec),
    .ram_addr    (ram_addr)
  );

  cbm_ram #(
    .WIDTH (cbm_pkg::DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_cart_ram (
    .clk   (clk),
    .en    (acc && dec.ram_en),
    .we    (dec.ram_we),
    .addr  (ram_addr),
    .wdata (bus.write_data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    case (s1_kind)
      cbm_pkg::KIND_RAM:  read_data_next = ram_rdata;
      cbm_pkg::KIND_OPEN: read_data_next = cbm_pkg::OPEN_BUS_BYTE;
      default:            read_data_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind        <= dec.kind;
      s1_rom_address <= dec.rom_address;
    end
    if (adv) begin
      out_kind        <= s1_kind;
      out_read_data   <= read_data_next;
      out_rom_address <= s1_rom_address;
    end
  end

  assign result.valid       = out_valid;
  assign result.access_kind = out_kind;
  assign result.read_data   = out_read_data;
  assign result.rom_address = out_rom_address;

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !bus.ready |-> (s1_valid && out_valid && !result.ready))
    else $error("input stalled without a full pipeline");

  a_open_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == cbm_pkg::KIND_OPEN) |-> out_read_data == cbm_pkg::OPEN_BUS_BYTE)
    else $error("open bus result without 0xFF");

  a_rom_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == cbm_pkg::KIND_ROM || out_kind == cbm_pkg::KIND_WRITE))
      |-> out_read_data == '0)
    else $error("nonzero read byte on ROM or write result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ===== rtl/cbm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_ram: generic single-port synchronous RAM
// One access per cycle; read data registered, held while not reading.
// ----------------------------------------------------------------------------
module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cbm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_ctrl: mapper registers and access decode
// Holds config and bank registers, decodes each bus word into a RAM access
// and a result kind, and updates the bank registers on accepted writes.
// ----------------------------------------------------------------------------
module cbm_ctrl #(
  parameter int RAM_BANK_NUM  = 4,
  parameter int ROM_SEL_BITS  = 5,
  parameter int RAM_AW        = $clog2(RAM_BANK_NUM * 8192)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              acc,
  input  wire logic                              mode,
  input  wire logic [cbm_pkg::ADDR_W-1:0]        bus_address,
  input  wire logic [cbm_pkg::DATA_W-1:0]        write_data,
  output cbm_pkg::dec_t                          dec,
  output logic      [RAM_AW-1:0]                 ram_addr
);

  localparam logic [4:0] ROM_WIDTH_MASK = 5'((1 << ROM_SEL_BITS) - 1);
  localparam logic [2:0] BANKS_MAX      = 3'(RAM_BANK_NUM);

  logic [4:0] rom_page_mask;
  logic [1:0] ram_page_mask;
  logic [2:0] ram_bank_count;
  logic       ram_enabled;
  logic [4:0] rom_select;
  logic [1:0] ram_bank_select;
  logic       bank_mode;

  logic [2:0] count_eff;
  logic [1:0] bank_used;
  logic       ram_ok;
  logic [4:0] rom_page;
  logic [4:0] rom_select_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_page_mask  <= 5'd31;
      ram_page_mask  <= 2'd3;
      ram_bank_count <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        cbm_pkg::REG_ROM_MASK:       rom_page_mask  <= cfg_data[4:0];
        cbm_pkg::REG_RAM_MASK:       ram_page_mask  <= cfg_data[1:0];
        cbm_pkg::REG_RAM_BANK_COUNT: ram_bank_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign rom_select_next = (write_data[4:0] != 5'd0) ? write_data[4:0] : 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled     <= 1'b0;
      rom_select      <= 5'd1;
      ram_bank_select <= 2'd0;
      bank_mode       <= 1'b0;
    end else if (acc && mode) begin
      case (bus_address) inside
        [16'h0000:16'h1FFF]:
          ram_enabled <= (write_data & cbm_pkg::RAM_EN_KEY) == cbm_pkg::RAM_EN_KEY;
        [16'h2000:16'h3FFF]: rom_select <= rom_select_next;
        [16'h4000:16'h5FFF]: ram_bank_select <= write_data[1:0] & ram_page_mask;
        [16'h6000:16'h7FFF]: bank_mode <= write_data[0];
        default: ;
      endcase
    end
  end

  assign count_eff = (ram_bank_count > BANKS_MAX) ? BANKS_MAX : ram_bank_count;
  assign bank_used = (!bank_mode || ram_bank_count == 3'd1) ? 2'd0 : ram_bank_select;
  assign ram_ok    = ram_enabled && ({1'b0, bank_used} < count_eff);
  assign rom_page  = rom_select & rom_page_mask & ROM_WIDTH_MASK;
  assign ram_addr  = RAM_AW'({bank_used, bus_address[cbm_pkg::BANK_OFS_W-1:0]});

  always_comb begin
    dec.kind        = mode ? cbm_pkg::KIND_WRITE : cbm_pkg::KIND_OPEN;
    dec.rom_address = '0;
    dec.ram_en      = 1'b0;
    dec.ram_we      = 1'b0;
    case (bus_address) inside
      [16'h0000:16'h3FFF]: begin
        if (!mode) begin
          dec.kind        = cbm_pkg::KIND_ROM;
          dec.rom_address = {5'd0, bus_address[13:0]};
        end
      end
      [16'h4000:16'h7FFF]: begin
        if (!mode) begin
          dec.kind        = cbm_pkg::KIND_ROM;
          dec.rom_address = {rom_page, bus_address[13:0]};
        end
      end
      [16'hA000:16'hBFFF]: begin
        dec.ram_en = ram_ok;
        dec.ram_we = ram_ok && mode;
        if (!mode && ram_ok) begin
          dec.kind = cbm_pkg::KIND_RAM;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== test/tb_cartridge_bank_mapper_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_top: self-checking bench for the bank mapper
// Drives bus access words and configuration writes, with random idle gaps on
// bus and result channels. A local copy of the bank registers and cart RAM
// predicts every result word, compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_top;

  localparam int BANKS      = 4;
  localparam int BANK_BYTES = 8192;

  typedef struct packed {
    cbm_pkg::kind_t                 kind;
    logic [cbm_pkg::DATA_W-1:0]     rdata;
    logic [cbm_pkg::ROM_ADDR_W-1:0] raddr;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbm_in_if  bus_if ();
  cbm_out_if res_if ();
  cbm_cfg_if cfg_if ();

  cartridge_bank_mapper_top #(
    .RAM_BANK_NUM (BANKS),
    .ROM_SEL_BITS (5)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .bus   (bus_if),
    .result(res_if),
    .cfg   (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mapper copy: configuration, bank registers, cart RAM
  logic [4:0] rom_mask;
  logic [1:0] ram_mask;
  logic [2:0] bank_count;
  logic       ram_on;
  logic [4:0] rom_sel;
  logic [1:0] ram_sel;
  logic       bank_mode;
  logic [7:0] ram_copy    [0:BANKS*BANK_BYTES-1];
  bit         ram_written [0:BANKS*BANK_BYTES-1];

  reply_t replies_q [$];
  int     fail_count = 0;
  bit     steady = 1'b0;

  function automatic bit ram_slot(input logic [15:0] a, output int unsigned ofs);
    int unsigned present;
    int unsigned bank;
    ofs = 0;
    present = (bank_count > 3'd4) ? BANKS : bank_count;
    bank = (!bank_mode || bank_count == 3'd1) ? 0 : ram_sel;
    if (!ram_on || bank >= present) return 1'b0;
    ofs = bank * BANK_BYTES + a[12:0];
    return 1'b1;
  endfunction

  function automatic reply_t step_mapper(input logic wr, input logic [15:0] a,
                                         input logic [7:0] d);
    reply_t r;
    int unsigned ofs;
    r.kind  = cbm_pkg::KIND_OPEN;
    r.rdata = cbm_pkg::OPEN_BUS_BYTE;
    r.raddr = '0;
    if (wr) begin
      r.kind  = cbm_pkg::KIND_WRITE;
      r.rdata = '0;
      if (a <= 16'h1FFF) ram_on = ((d & cbm_pkg::RAM_EN_KEY) == cbm_pkg::RAM_EN_KEY);
      else if (a <= 16'h3FFF) rom_sel = (d[4:0] != 5'd0) ? d[4:0] : 5'd1;
      else if (a <= 16'h5FFF) ram_sel = d[1:0] & ram_mask;
      else if (a <= 16'h7FFF) bank_mode = d[0];
      else if (a >= 16'hA000 && a <= 16'hBFFF && ram_slot(a, ofs)) begin
        ram_copy[ofs]    = d;
        ram_written[ofs] = 1'b1;
      end
    end else if (a <= 16'h3FFF) begin
      r.kind  = cbm_pkg::KIND_ROM;
      r.rdata = '0;
      r.raddr = {3'b000, a};
    end else if (a <= 16'h7FFF) begin
      r.kind  = cbm_pkg::KIND_ROM;
      r.rdata = '0;
      r.raddr = {rom_sel & rom_mask, a[13:0]};
    end else if (a >= 16'hA000 && a <= 16'hBFFF && ram_slot(a, ofs)) begin
      r.kind  = cbm_pkg::KIND_RAM;
      r.rdata = ram_copy[ofs];
    end
    return r;
  endfunction

  // a read that would return a cart RAM byte never written
  function automatic bit blank_read(input logic wr, input logic [15:0] a);
    int unsigned ofs;
    if (wr || a < 16'hA000 || a > 16'hBFFF) return 1'b0;
    if (!ram_slot(a, ofs)) return 1'b0;
    return !ram_written[ofs];
  endfunction

  task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] d);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      bus_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bus_if.valid       <= 1'b1;
    bus_if.mode        <= wr;
    bus_if.bus_address <= a;
    bus_if.write_data  <= d;
    do @(posedge clk); while (!bus_if.ready);
    replies_q.push_back(step_mapper(wr, a, d));
  endtask

  task automatic drain_bus();
    bus_if.valid <= 1'b0;
    while (replies_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cbm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    drain_bus();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      cbm_pkg::REG_ROM_MASK:       rom_mask   = val[4:0];
      cbm_pkg::REG_RAM_MASK:       ram_mask   = val[1:0];
      cbm_pkg::REG_RAM_BANK_COUNT: bank_count = val[2:0];
      default: ;
    endcase
  endtask

  task automatic test_rom_mapping();
    send_access(1'b0, 16'h0000, 8'h00);
    send_access(1'b0, 16'h3FFF, 8'hFF);
    send_access(1'b0, 16'h4000, 8'h00);
    send_access(1'b1, 16'h2000, 8'h00);  // bank 0 selects bank 1
    send_access(1'b0, 16'h7FFF, 8'h00);
    send_access(1'b1, 16'h3FFF, 8'hFF);
    send_access(1'b0, 16'h7FFF, 8'h00);
    send_access(1'b1, 16'h2000, 8'hE0);  // low bits zero -> bank 1
    send_access(1'b0, 16'h4000, 8'h00);
  endtask

  task automatic test_ram_gating();
    send_access(1'b0, 16'hA000, 8'h00);  // disabled
    send_access(1'b1, 16'h0000, 8'h0A);
    send_access(1'b1, 16'hA000, 8'h5A);
    send_access(1'b1, 16'h1FFF, 8'h08);  // key incomplete -> disabled
    send_access(1'b1, 16'hA000, 8'hA5);  // dropped
    send_access(1'b0, 16'hA000, 8'h00);
    send_access(1'b1, 16'h1000, 8'hFA);
    send_access(1'b0, 16'hA000, 8'h00);
    send_access(1'b1, 16'hBFFF, 8'hFF);
    send_access(1'b0, 16'hBFFF, 8'h00);
    send_access(1'b0, 16'h8000, 8'h00);
    send_access(1'b1, 16'h9FFF, 8'h00);
    send_access(1'b0, 16'hC000, 8'h00);
    send_access(1'b0, 16'hFFFF, 8'h00);
  endtask

  task automatic test_bank_registers();
    write_reg(cbm_pkg::REG_RAM_BANK_COUNT, 8'd4);
    write_reg(cbm_pkg::REG_ROM_MASK, 8'd0);
    write_reg(cbm_pkg::REG_RAM_MASK, 8'd1);
    send_access(1'b1, 16'h6000, 8'h01);
    send_access(1'b1, 16'h4000, 8'hFF);  // masked to bank 1
    send_access(1'b1, 16'hA123, 8'h3C);
    send_access(1'b0, 16'hA123, 8'h00);
    send_access(1'b0, 16'h4000, 8'h00);
    write_reg(cbm_pkg::REG_RAM_BANK_COUNT, 8'd0);  // no RAM
    send_access(1'b0, 16'hA123, 8'h00);
    write_reg(cbm_pkg::REG_RAM_BANK_COUNT, 8'd7);  // clamps to four banks
    write_reg(cbm_pkg::REG_RAM_MASK, 8'd3);
    send_access(1'b1, 16'h5FFF, 8'h03);
    send_access(1'b1, 16'hB000, 8'h77);
    send_access(1'b0, 16'hB000, 8'h00);
    write_reg(cbm_pkg::REG_RAM_BANK_COUNT, 8'd1);  // single bank ignores mode
    send_access(1'b0, 16'hA000, 8'h00);
    send_access(1'b1, 16'h7FFF, 8'h00);
  endtask

  task automatic test_random_traffic();
    logic [12:0] spots [16];
    logic        wr;
    logic [15:0] a;
    logic [7:0]  d;
    int          sel;
    int          region;
    spots[0] = 13'h0000;
    spots[1] = 13'h1FFF;
    spots[2] = 13'h0AAA;
    spots[3] = 13'h1555;
    for (int i = 4; i < 16; i++) spots[i] = 13'($urandom);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(cbm_pkg::REG_ROM_MASK, 8'd31);
          write_reg(cbm_pkg::REG_RAM_MASK, 8'd3);
          write_reg(cbm_pkg::REG_RAM_BANK_COUNT, 8'd4);
        end
        1: begin
          write_reg(cbm_pkg::REG_ROM_MASK, 8'd0);
          write_reg(cbm_pkg::REG_RAM_MASK, 8'd0);
          write_reg(cbm_pkg::REG_RAM_BANK_COUNT, 8'd0);
        end
        default: begin
          write_reg(cbm_pkg::REG_ROM_MASK, 8'($urandom_range(0, 31)));
          write_reg(cbm_pkg::REG_RAM_MASK, 8'($urandom_range(0, 3)));
          write_reg(cbm_pkg::REG_RAM_BANK_COUNT, ($urandom_range(0, 5) == 0) ?
                    8'($urandom_range(0, 7)) : 8'($urandom_range(1, 4)));
        end
      endcase
      for (int n = 0; n < 85; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        sel = $urandom_range(0, 99);
        wr  = 1'($urandom_range(0, 1));
        d   = 8'($urandom);
        if (sel < 25) begin
          wr     = 1'b1;
          region = $urandom_range(0, 3);
          a      = {1'b0, 2'(region), 13'($urandom)};
          if (region == 0 && $urandom_range(0, 3) != 0) d = d | cbm_pkg::RAM_EN_KEY;
        end else if (sel < 45) begin
          wr = 1'b0;
          a  = 16'($urandom_range(0, 16'h7FFF));
        end else if (sel < 85) begin
          a = {3'b101, spots[$urandom_range(0, 15)]};
        end else if (sel < 93) begin
          a = $urandom_range(0, 1) ? 16'($urandom_range(16'h8000, 16'h9FFF)) :
                                     16'($urandom_range(16'hC000, 16'hFFFF));
        end else begin
          a = 16'($urandom);
        end
        if (blank_read(wr, a)) wr = 1'b1;
        send_access(wr, a, d);
      end
    end
    steady = 1'b0;
  endtask

  initial begin : result_sink
    int     stall;
    reply_t want;
    res_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      if (replies_q.size() == 0) begin
        $display("%0t: unexpected word: kind %0d data %h rom %h", $time,
                 res_if.access_kind, res_if.read_data, res_if.rom_address);
        fail_count++;
      end else begin
        want = replies_q.pop_front();
        if (res_if.access_kind !== want.kind) begin
          $display("%0t: access_kind expected %0d actual %0d", $time,
                   want.kind, res_if.access_kind);
          fail_count++;
        end
        if (res_if.read_data !== want.rdata) begin
          $display("%0t: read_data expected %h actual %h", $time,
                   want.rdata, res_if.read_data);
          fail_count++;
        end
        if (res_if.rom_address !== want.raddr) begin
          $display("%0t: rom_address expected %h actual %h", $time,
                   want.raddr, res_if.rom_address);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_cartridge_bank_mapper_top failed");
    $finish;
  end

  initial begin
    bus_if.valid       <= 1'b0;
    bus_if.mode        <= 1'b0;
    bus_if.bus_address <= '0;
    bus_if.write_data  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= cbm_pkg::REG_ROM_MASK;
    cfg_if.data        <= '0;
    rom_mask   = 5'd31;
    ram_mask   = 2'd3;
    bank_count = 3'd1;
    ram_on     = 1'b0;
    rom_sel    = 5'd1;
    ram_sel    = 2'd0;
    bank_mode  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_rom_mapping();
    test_ram_gating();
    test_bank_registers();
    test_random_traffic();
    drain_bus();
    if (fail_count == 0) begin
      $display("tb_cartridge_bank_mapper_top passed");
    end else begin
      $display("tb_cartridge_bank_mapper_top failed");
    end
    $finish;
  end

endmodule
